// ===== hdl/kgr_pkg.sv =====
package kgr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int ADDR_W    = $clog2(MAX_GROUP);
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(2);

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } t_state;

    typedef struct packed {
        logic en;
        logic last;
        logic list_end;
    } t_rd;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] g);
        logic [CNT_W-1:0] k;
        if (g == '0) begin
            k = CNT_W'(1);
        end else if (CNT_W'(g) > CNT_W'(MAX_GROUP)) begin
            k = CNT_W'(MAX_GROUP);
        end else begin
            k = CNT_W'(g);
        end
        return k;
    endfunction

endpackage

// ===== hdl/k_group_reverse_reorder.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_group_size
// input    | i_valid / o_ready          | i_item_value, i_is_final
// output   | o_valid / i_ready          | o_out_value, o_burst_last, o_list_end
//
// An input transaction is written to the group buffer RAM.
// A closing transaction starts a burst of n reads from the one RAM read port, one per
// cycle while the output is not stalled; input is not accepted until the burst ends.
// Two output stages (RAM read register and output register) absorb output stalls.
// Reset is synchronous, active low; group size resets to 2, fill count to zero.
module k_group_reverse_reorder
    import kgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_group_size,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [DATA_W-1:0] i_item_value,
    input  logic              i_is_final,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_burst_last,
    output logic              o_list_end
);

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [DATA_W-1:0] rdata;
    logic              issue_ok;
    t_rd               rd;

    kgr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_group_size (i_cfg_group_size),
        .o_cfg_ready      (o_cfg_ready),
        .i_valid          (i_valid),
        .i_is_final       (i_is_final),
        .o_ready          (o_ready),
        .i_issue_ok       (issue_ok),
        .o_we             (we),
        .o_waddr          (waddr),
        .o_raddr          (raddr),
        .o_rd             (rd)
    );

    kgr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_GROUP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item_value),
        .i_re    (rd.en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    kgr_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd         (rd),
        .i_rdata      (rdata),
        .o_issue_ok   (issue_ok),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_value  (o_out_value),
        .o_burst_last (o_burst_last),
        .o_list_end   (o_list_end)
    );

endmodule

// ===== hdl/kgr_ram.sv =====
module kgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kgr_ctrl.sv =====
module kgr_ctrl
    import kgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_group_size,
    output logic              o_cfg_ready,
    input  logic              i_valid,
    input  logic              i_is_final,
    output logic              o_ready,
    input  logic              i_issue_ok,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [ADDR_W-1:0] o_raddr,
    output t_rd               o_rd
);

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_group, n_group;
    logic [CNT_W-1:0]   r_fill,  n_fill;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [ADDR_W-1:0]  r_idx,   n_idx;
    logic               r_rev,   n_rev;
    logic               r_fin,   n_fin;
    logic [CNT_W-1:0]   fill_inc;
    logic [CNT_W-1:0]   k;
    logic               accept;
    logic               full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_group <= GROUP_SIZE_RST;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_group <= n_group;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_rev <= n_rev;
        r_fin <= n_fin;
    end

    assign o_cfg_ready = 1'b1;
    assign fill_inc    = r_fill + CNT_W'(1);
    assign k           = eff_size(r_group);
    assign full        = (fill_inc >= k);
    assign o_waddr     = r_fill[ADDR_W-1:0];
    assign o_raddr     = r_idx;

    always_comb begin
        n_state = r_state;
        n_group = r_group;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_rev   = r_rev;
        n_fin   = r_fin;
        o_ready = 1'b0;
        o_we    = 1'b0;
        accept  = 1'b0;
        o_rd    = '0;

        if (i_cfg_valid) begin
            n_group = i_cfg_group_size;
        end

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                accept  = i_valid;
                if (accept) begin
                    o_we   = 1'b1;
                    n_fill = fill_inc;
                    if (full || i_is_final) begin
                        n_cnt   = fill_inc;
                        n_rev   = full;
                        n_idx   = full ? r_fill[ADDR_W-1:0] : '0;
                        n_fin   = i_is_final;
                        n_fill  = '0;
                        n_state = ST_BURST;
                    end
                end
            end
            ST_BURST: begin
                if (i_issue_ok) begin
                    o_rd.en       = 1'b1;
                    o_rd.last     = (r_cnt == CNT_W'(1));
                    o_rd.list_end = o_rd.last && r_fin;
                    n_cnt         = r_cnt - CNT_W'(1);
                    n_idx         = r_rev ? r_idx - ADDR_W'(1) : r_idx + ADDR_W'(1);
                    if (o_rd.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(MAX_GROUP))
        else $error("fill count reached buffer depth");

    a_burst_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BURST) |-> (r_cnt != '0) && (r_fill == '0))
        else $error("burst with no pending reads or nonzero fill");

    a_burst_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BURST && o_rd.en && o_rd.last) |=> (r_state == ST_IDLE))
        else $error("burst did not end after last read");

    a_no_write_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd.en |-> !o_we)
        else $error("buffer write during burst");
`endif

endmodule

// ===== hdl/kgr_out.sv =====
module kgr_out
    import kgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rd               i_rd,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_issue_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_burst_last,
    output logic              o_list_end
);

    logic              r_a_valid;
    logic              r_a_last;
    logic              r_a_end;
    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    logic              r_last;
    logic              r_end;
    logic              b_load;

    assign b_load     = r_a_valid && (!r_valid || i_ready);
    assign o_issue_ok = !r_a_valid || b_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_rd.en) begin
                r_a_valid <= 1'b1;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_a_last <= i_rd.last;
            r_a_end  <= i_rd.list_end;
        end
        if (b_load) begin
            r_value <= i_rdata;
            r_last  <= r_a_last;
            r_end   <= r_a_end;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_value  = r_value;
    assign o_burst_last = r_last;
    assign o_list_end   = r_end;

endmodule
